// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (c)) else $error("lbl");
`else
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, a, c)
`define ASSERT_NEXT(lbl, clk_s, rst_s, a, c)
`endif
`endif

// ===== hw/rtl/parl_pkg.sv =====
// types and constants for the peer admission rate limiter
// no dependencies
package parl_pkg;
  localparam int PEER_SLOTS = 64;
  localparam int SLOT_W = $clog2(PEER_SLOTS);
  localparam int CNT_W = SLOT_W + 1;

  typedef enum logic [2:0] {
    ACT_ACQUIRE = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_CHARGE  = 3'd2,
    ACT_CHUNK   = 3'd3,
    ACT_QUERY   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_MAX_INFLIGHT = 2'd1,
    CFG_PEER_CAP = 2'd2,
    CFG_GLOBAL_CAP = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] peer_addr_high;
    logic [63:0] peer_addr_low;
    logic [31:0] byte_count;
    logic [31:0] time_seconds;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [63:0] chunks_total;
    logic [63:0] byte_sum;
    logic [31:0] distinct_peers;
    logic [63:0] current_rate;
  } out_item_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        charged_once;
    logic [15:0] inflight;
    logic [31:0] window_start;
    logic [63:0] window_bytes;
    logic [31:0] seen_at;
  } slot_t;
endpackage

// ===== hw/rtl/peer_admission_rate_limiter.sv =====
// peer admission rate limiter top level
// depends on parl_pkg and assert_macros.svh
// One request at a time. The slot table is a memory of PEER_SLOTS entries read one
// entry per cycle: a request scans upward for a matching or free slot, and a
// full-table miss adds a second pass over all slots for the oldest idle entry. Used
// bits are flip-flops cleared at reset; an unused entry reads as zero.
`include "assert_macros.svh"
module peer_admission_rate_limiter
  import parl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  localparam logic [63:0] ALL_ONES = '1;

  slot_t mem [PEER_SLOTS];
  slot_t rd;
  logic [PEER_SLOTS-1:0] used;

  state_t state, state_next;
  in_item_t req;
  logic [CNT_W-1:0] idx;
  logic [SLOT_W-1:0] pick;
  logic pick_ok;
  logic [31:0] pick_seen;
  logic found, fresh;

  logic        serve_enable;
  logic [15:0] max_inflight;
  logic [47:0] peer_byte_cap, global_byte_cap;
  logic [31:0] global_window_start, peer_counter;
  logic [63:0] global_window_bytes, chunk_counter, byte_counter;

  logic [SLOT_W-1:0] ridx;
  logic rd_used;
  slot_t ent;
  logic hit, older;
  logic [63:0] gsum, psum, gbase, pbase;
  logic ok_g, ok_p;

  logic        grant_now;
  logic [63:0] rate_now;
  logic [63:0] chunk_counter_next, byte_counter_next;
  logic [31:0] peer_counter_next;

  assign in_stall = (state != ST_IDLE);
  assign ridx = idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    rd <= mem[ridx];
    rd_used <= used[ridx];
  end

  assign ent = rd_used ? rd : '0;
  assign hit = !rd_used || (rd.addr_high == req.peer_addr_high &&
                            rd.addr_low == req.peer_addr_low);
  assign older = (idx != '0) && (ent.inflight == '0) &&
                 (!pick_ok || ent.seen_at < pick_seen);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (idx != '0 && hit) state_next = ST_READ;
        else if (idx == CNT_W'(PEER_SLOTS)) state_next = ST_EVICT;
      end
      ST_EVICT:  if (idx == CNT_W'(PEER_SLOTS)) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign gbase = (req.time_seconds != global_window_start) ? '0 : global_window_bytes;
  assign gsum = (gbase > ALL_ONES - {32'd0, req.byte_count}) ? ALL_ONES
              : gbase + {32'd0, req.byte_count};
  assign pbase = (fresh || req.time_seconds != ent.window_start) ? '0 : ent.window_bytes;
  assign psum = (pbase > ALL_ONES - {32'd0, req.byte_count}) ? ALL_ONES
              : pbase + {32'd0, req.byte_count};
  assign ok_g = !(gsum > {16'd0, global_byte_cap});
  assign ok_p = !(psum > {16'd0, peer_byte_cap});

  always_comb begin
    grant_now = 1'b0;
    rate_now = (req.time_seconds == global_window_start) ? global_window_bytes : '0;
    chunk_counter_next = chunk_counter;
    byte_counter_next = byte_counter;
    peer_counter_next = peer_counter;
    case (req.action)
      ACT_ACQUIRE: begin
        grant_now = serve_enable && found && (fresh || ent.inflight < max_inflight);
      end
      ACT_CHARGE: begin
        rate_now = gsum;
        if (found && ok_g && ok_p) begin
          grant_now = 1'b1;
          byte_counter_next = byte_counter + {32'd0, req.byte_count};
          if (fresh || !ent.charged_once) peer_counter_next = peer_counter + 32'd1;
        end
      end
      ACT_CHUNK: chunk_counter_next = chunk_counter + 64'd1;
      default: ;
    endcase
  end

  // scan: idx is address issued, compare uses the registered entry read for the previous idx
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used <= '0;
      out_valid <= 1'b0;
      serve_enable <= 1'b1;
      max_inflight <= 16'd4;
      peer_byte_cap <= 48'd1048576;
      global_byte_cap <= 48'd16777216;
      global_window_start <= '0;
      global_window_bytes <= '0;
      chunk_counter <= '0;
      byte_counter <= '0;
      peer_counter <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_ENABLE:       serve_enable <= cfg_data[0];
          CFG_MAX_INFLIGHT: max_inflight <= (cfg_data[15:0] == '0) ? 16'd1 : cfg_data[15:0];
          CFG_PEER_CAP:     peer_byte_cap <= (cfg_data == '0) ? 48'd1 : cfg_data;
          CFG_GLOBAL_CAP:   global_byte_cap <= (cfg_data == '0) ? 48'd1 : cfg_data;
          default: ;
        endcase
      end
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            idx <= '0;
            pick_ok <= 1'b0;
            found <= 1'b0;
            fresh <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (idx != '0 && hit) begin
            pick <= ridx - 1'b1;
            found <= 1'b1;
            fresh <= !rd_used;
            idx <= {1'b0, ridx - 1'b1};
          end else if (idx == CNT_W'(PEER_SLOTS)) begin
            idx <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_EVICT: begin
          if (older) begin
            pick_ok <= 1'b1;
            pick <= ridx - 1'b1;
            pick_seen <= ent.seen_at;
          end
          if (idx == CNT_W'(PEER_SLOTS)) begin
            found <= pick_ok || older;
            fresh <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_READ: begin
          idx <= {1'b0, pick};
        end
        ST_UPDATE: begin
          out_valid <= 1'b1;
          out_data <= '{granted: grant_now, chunks_total: chunk_counter_next,
                        byte_sum: byte_counter_next, distinct_peers: peer_counter_next,
                        current_rate: rate_now};
          chunk_counter <= chunk_counter_next;
          byte_counter <= byte_counter_next;
          peer_counter <= peer_counter_next;
          case (req.action)
            ACT_ACQUIRE: begin
              if (serve_enable && found) begin
                mem[pick] <= '{addr_high: req.peer_addr_high, addr_low: req.peer_addr_low,
                  charged_once: fresh ? 1'b0 : ent.charged_once,
                  inflight: (fresh ? 16'd0 : ent.inflight) +
                            16'((fresh ? 16'd0 : ent.inflight) < max_inflight),
                  window_start: fresh ? req.time_seconds : ent.window_start,
                  window_bytes: fresh ? 64'd0 : ent.window_bytes,
                  seen_at: req.time_seconds};
                used[pick] <= 1'b1;
              end
            end
            ACT_RELEASE: begin
              if (found && !fresh && ent.inflight != '0) begin
                mem[pick] <= '{addr_high: ent.addr_high, addr_low: ent.addr_low,
                  charged_once: ent.charged_once, inflight: ent.inflight - 16'd1,
                  window_start: ent.window_start, window_bytes: ent.window_bytes,
                  seen_at: ent.seen_at};
              end
            end
            ACT_CHARGE: begin
              global_window_start <= req.time_seconds;
              global_window_bytes <= gsum;
              if (found) begin
                mem[pick] <= '{addr_high: req.peer_addr_high, addr_low: req.peer_addr_low,
                  charged_once: (fresh ? 1'b0 : ent.charged_once) | (ok_g & ok_p),
                  inflight: fresh ? 16'd0 : ent.inflight,
                  window_start: req.time_seconds, window_bytes: psum,
                  seen_at: req.time_seconds};
                used[pick] <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          if (!out_stall) out_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_busy_stall, clk, rst, state != ST_IDLE, in_stall)
  `ASSERT_IMPLIES(a_out_in_done, clk, rst, out_valid, state == ST_DONE)
  `ASSERT_NEXT(a_done_clears, clk, rst, out_valid && !out_stall, !out_valid)
endmodule

// ===== test/tb.sv =====
// testbench for peer_admission_rate_limiter: request transfers from a queue, results
// checked against a behavioral table model kept in the bench
// depends on parl_pkg and the rtl top level
module tb;
  import parl_pkg::*;

  localparam int NSLOT = PEER_SLOTS;
  localparam logic [63:0] MAX64 = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  peer_admission_rate_limiter dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the limiter state
  logic        m_enable;
  logic [15:0] m_max_inflight;
  logic [47:0] m_peer_cap, m_global_cap;
  logic [63:0] m_hi [NSLOT];
  logic [63:0] m_lo [NSLOT];
  logic        m_used [NSLOT];
  logic        m_served [NSLOT];
  logic [15:0] m_inflight [NSLOT];
  logic [31:0] m_wstart [NSLOT];
  logic [63:0] m_wbytes [NSLOT];
  logic [31:0] m_seen [NSLOT];
  logic [31:0] m_gstart;
  logic [63:0] m_gbytes, m_chunks, m_bytes;
  logic [31:0] m_peers;

  in_item_t  pending_requests[$];
  out_item_t expected_grants[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? MAX64 : s[63:0];
  endfunction

  function automatic void clear_entry(int i);
    m_hi[i] = '0; m_lo[i] = '0; m_used[i] = 1'b0; m_served[i] = 1'b0;
    m_inflight[i] = '0; m_wstart[i] = '0; m_wbytes[i] = '0; m_seen[i] = '0;
  endfunction

  function automatic void limiter_reset();
    m_enable = 1'b1; m_max_inflight = 16'd4;
    m_peer_cap = 48'd1048576; m_global_cap = 48'd16777216;
    for (int i = 0; i < NSLOT; i++) clear_entry(i);
    m_gstart = '0; m_gbytes = '0; m_chunks = '0; m_bytes = '0; m_peers = '0;
  endfunction

  function automatic void limiter_config(cfg_index_t idx, logic [47:0] v);
    case (idx)
      CFG_ENABLE: m_enable = v[0];
      CFG_MAX_INFLIGHT: m_max_inflight = (v[15:0] == '0) ? 16'd1 : v[15:0];
      CFG_PEER_CAP: m_peer_cap = (v == '0) ? 48'd1 : v;
      CFG_GLOBAL_CAP: m_global_cap = (v == '0) ? 48'd1 : v;
      default: ;
    endcase
  endfunction

  function automatic int lookup_peer(logic [63:0] hi, logic [63:0] lo);
    int pick;
    pick = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!m_used[i]) return i;
      if (m_hi[i] == hi && m_lo[i] == lo) return i;
    end
    for (int i = 0; i < NSLOT; i++)
      if (m_inflight[i] == '0 && (pick < 0 || m_seen[i] < m_seen[pick])) pick = i;
    if (pick >= 0) clear_entry(pick);
    return pick;
  endfunction

  function automatic out_item_t admit_request(in_item_t r);
    out_item_t o;
    int s;
    bit ok;
    logic [31:0] now;
    logic [63:0] n;
    now = r.time_seconds;
    n = {32'd0, r.byte_count};
    o = '0;
    case (r.action)
      ACT_ACQUIRE: begin
        if (m_enable) begin
          s = lookup_peer(r.peer_addr_high, r.peer_addr_low);
          if (s >= 0) begin
            if (!m_used[s]) begin
              m_used[s] = 1'b1; m_hi[s] = r.peer_addr_high; m_lo[s] = r.peer_addr_low;
              m_wstart[s] = now;
            end
            m_seen[s] = now;
            if (m_inflight[s] < m_max_inflight) begin
              m_inflight[s] = m_inflight[s] + 16'd1;
              o.granted = 1'b1;
            end
          end
        end
      end
      ACT_RELEASE: begin
        for (int i = 0; i < NSLOT; i++)
          if (m_used[i] && m_hi[i] == r.peer_addr_high && m_lo[i] == r.peer_addr_low) begin
            if (m_inflight[i] > 16'd0) m_inflight[i] = m_inflight[i] - 16'd1;
            break;
          end
      end
      ACT_CHARGE: begin
        ok = 1'b1;
        if (now != m_gstart) begin
          m_gstart = now; m_gbytes = '0;
        end
        m_gbytes = sat_sum(m_gbytes, n);
        if (m_gbytes > {16'd0, m_global_cap}) ok = 1'b0;
        s = lookup_peer(r.peer_addr_high, r.peer_addr_low);
        if (s >= 0) begin
          if (!m_used[s]) begin
            m_used[s] = 1'b1; m_hi[s] = r.peer_addr_high; m_lo[s] = r.peer_addr_low;
            m_wstart[s] = now; m_wbytes[s] = '0;
          end
          if (now != m_wstart[s]) begin
            m_wstart[s] = now; m_wbytes[s] = '0;
          end
          m_seen[s] = now;
          m_wbytes[s] = sat_sum(m_wbytes[s], n);
          if (m_wbytes[s] > {16'd0, m_peer_cap}) ok = 1'b0;
          if (ok) begin
            if (!m_served[s]) begin
              m_served[s] = 1'b1; m_peers = m_peers + 32'd1;
            end
            m_bytes = m_bytes + n;
          end
        end else ok = 1'b0;
        o.granted = ok;
      end
      ACT_CHUNK: m_chunks = m_chunks + 64'd1;
      default: ;
    endcase
    o.chunks_total = m_chunks;
    o.byte_sum = m_bytes;
    o.distinct_peers = m_peers;
    o.current_rate = (now == m_gstart) ? m_gbytes : '0;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_grants.push_back(admit_request(in_data));
        sent++;
      end
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      received++;
      if (expected_grants.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_grants.pop_front();
        if (out_data.granted !== e.granted) begin
          $error("granted exp %0h got %0h", e.granted, out_data.granted); errors++;
        end
        if (out_data.chunks_total !== e.chunks_total) begin
          $error("chunks_total exp %0h got %0h", e.chunks_total, out_data.chunks_total);
          errors++;
        end
        if (out_data.byte_sum !== e.byte_sum) begin
          $error("byte_sum exp %0h got %0h", e.byte_sum, out_data.byte_sum);
          errors++;
        end
        if (out_data.distinct_peers !== e.distinct_peers) begin
          $error("distinct_peers exp %0h got %0h", e.distinct_peers, out_data.distinct_peers);
          errors++;
        end
        if (out_data.current_rate !== e.current_rate) begin
          $error("current_rate exp %0h got %0h", e.current_rate, out_data.current_rate);
          errors++;
        end
      end
    end
  end

  // receiver stall, with a long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off && hold_cycles < 600) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_item_t make_req(action_t a, logic [63:0] hi, logic [63:0] lo,
                                        logic [31:0] n, logic [31:0] t);
    in_item_t r;
    r.action = a; r.peer_addr_high = hi; r.peer_addr_low = lo;
    r.byte_count = n; r.time_seconds = t;
    return r;
  endfunction

  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [47:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limiter_config(idx, v);
  endtask

  // random traffic over a small peer pool so entries get reused and evicted
  task automatic queue_random(int count, int pool, logic [31:0] t0);
    logic [31:0] t;
    logic [63:0] hi, lo;
    int k, a;
    logic [2:0] act;
    t = t0;
    for (int j = 0; j < count; j++) begin
      if ($urandom_range(9) == 0) t = t + $urandom_range(2);
      k = $urandom_range(pool - 1);
      hi = {32'hA5A5_0000, 32'(k)};
      lo = {32'(k * 7), 32'h0000_1234};
      if ($urandom_range(19) == 0) begin
        hi = {$urandom, $urandom}; lo = {$urandom, $urandom};
      end
      a = $urandom_range(99);
      if (a < 30) act = ACT_ACQUIRE;
      else if (a < 55) act = ACT_RELEASE;
      else if (a < 85) act = ACT_CHARGE;
      else if (a < 92) act = ACT_CHUNK;
      else if (a < 97) act = ACT_QUERY;
      else act = 3'($urandom_range(7, 5));
      pending_requests.push_back(make_req(action_t'(act), hi, lo,
        ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(300000)),
        ($urandom_range(49) == 0) ? $urandom : t));
    end
  endtask

  initial begin
    limiter_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: every action, field extremes, unknown actions, disabled acquire
    pending_requests.push_back(make_req(ACT_QUERY, '0, '0, '0, '0));
    pending_requests.push_back(make_req(ACT_ACQUIRE, '0, '0, '0, '0));
    pending_requests.push_back(make_req(ACT_ACQUIRE, MAX64, MAX64, '1, '1));
    pending_requests.push_back(make_req(ACT_RELEASE, MAX64, MAX64, '0, '1));
    pending_requests.push_back(make_req(ACT_RELEASE, MAX64, MAX64, '0, '1));
    pending_requests.push_back(make_req(ACT_RELEASE, 64'd5, 64'd6, '0, '1));
    pending_requests.push_back(make_req(ACT_CHARGE, 64'd1, 64'd2, 32'd1000, 32'd10));
    pending_requests.push_back(make_req(ACT_CHARGE, 64'd1, 64'd2, 32'd2000000, 32'd10));
    pending_requests.push_back(make_req(ACT_CHARGE, 64'd1, 64'd2, '1, 32'd11));
    pending_requests.push_back(make_req(ACT_CHARGE, 64'd1, 64'd2, 32'd5, 32'd12));
    pending_requests.push_back(make_req(ACT_CHUNK, '0, '0, '0, 32'd12));
    pending_requests.push_back(make_req(ACT_QUERY, '0, '0, '0, 32'd11));
    pending_requests.push_back(make_req(action_t'(3'd5), '0, '0, '0, 32'd12));
    pending_requests.push_back(make_req(action_t'(3'd7), MAX64, '0, '1, 32'd12));
    for (int i = 0; i < 5; i++)
      pending_requests.push_back(make_req(ACT_ACQUIRE, 64'd9, 64'd9, '0, 32'd13));
    drain();
    write_reg(CFG_ENABLE, 48'd0);
    pending_requests.push_back(make_req(ACT_ACQUIRE, 64'd3, 64'd3, '0, 32'd14));
    pending_requests.push_back(make_req(ACT_CHARGE, 64'd3, 64'd3, 32'd10, 32'd14));
    drain();
    write_reg(CFG_ENABLE, 48'd1);

    // fill the table with busy peers, then force eviction and a full-busy miss
    write_reg(CFG_MAX_INFLIGHT, 48'd0);
    for (int i = 0; i < NSLOT; i++)
      pending_requests.push_back(make_req(ACT_ACQUIRE, 64'hBEEF, 64'(i), '0, 32'(100 + i)));
    pending_requests.push_back(make_req(ACT_CHARGE, 64'hCAFE, 64'd1, 32'd1, 32'd200));
    pending_requests.push_back(make_req(ACT_ACQUIRE, 64'hCAFE, 64'd1, '0, 32'd200));
    pending_requests.push_back(make_req(ACT_RELEASE, 64'hBEEF, 64'd7, '0, 32'd200));
    pending_requests.push_back(make_req(ACT_RELEASE, 64'hBEEF, 64'd3, '0, 32'd200));
    pending_requests.push_back(make_req(ACT_CHARGE, 64'hCAFE, 64'd2, 32'd1, 32'd201));
    pending_requests.push_back(make_req(ACT_ACQUIRE, 64'hCAFE, 64'd3, '0, 32'd201));
    drain();

    // random phases with different settings and idling
    write_reg(CFG_MAX_INFLIGHT, 48'd65535);
    write_reg(CFG_PEER_CAP, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_GLOBAL_CAP, 48'hFFFF_FFFF_FFFF);
    queue_random(300, 80, 32'd1000);
    drain();

    write_reg(CFG_MAX_INFLIGHT, 48'd2);
    write_reg(CFG_PEER_CAP, 48'd400000);
    write_reg(CFG_GLOBAL_CAP, 48'd1500000);
    send_idle_pct = 75;
    queue_random(300, 40, 32'd5000);
    drain();

    write_reg(CFG_MAX_INFLIGHT, 48'd1);
    write_reg(CFG_PEER_CAP, 48'd0);
    write_reg(CFG_GLOBAL_CAP, 48'd1);
    send_idle_pct = 0; stall_pct = 75;
    queue_random(150, 70, 32'd9000);
    drain();

    write_reg(CFG_MAX_INFLIGHT, 48'd3);
    write_reg(CFG_PEER_CAP, 48'd1048576);
    write_reg(CFG_GLOBAL_CAP, 48'd0);
    send_idle_pct = 35; stall_pct = 35;
    queue_random(250, 90, 32'd20000);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_reg(CFG_GLOBAL_CAP, 48'd16777216);
    send_idle_pct = 0; stall_pct = 0;
    hold_off = 1'b1;
    queue_random(300, 60, 32'hFFFF_FFF0);
    drain();

    $display("covered %0d request transfers and %0d result transfers", sent, received);
    $display("over six settings phases, table eviction and a long output hold-off");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
